@@ rtl/lmdv_pkg.sv @@
package lmdv_pkg;

   localparam int DEPTH_W    = 12;
   localparam int STEP_W     = 24;
   localparam int SHAPE_W    = 2;
   localparam int LENGTH_W   = 13;
   localparam int BACK_W     = 13;
   localparam int LFO_W      = 17;
   localparam int PHASE_W    = 32;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 24;

   localparam logic [CSR_ADDR_W-1:0] CSR_MOD_DEPTH    = 4'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_PHASE_STEP   = 4'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_LFO_SHAPE    = 4'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_DELAY_LENGTH = 4'd3;

   localparam logic [DEPTH_W-1:0]  RST_MOD_DEPTH    = 12'd480;
   localparam logic [STEP_W-1:0]   RST_PHASE_STEP   = 24'd178957;
   localparam logic [LENGTH_W-1:0] RST_DELAY_LENGTH = 13'd2401;

   typedef enum logic [SHAPE_W-1:0] {
      SHAPE_SINE = 2'd0,
      SHAPE_TRI  = 2'd1,
      SHAPE_RISE = 2'd2,
      SHAPE_FALL = 2'd3
   } lfo_shape_type;

endpackage

@@ rtl/lfo_modulated_delay_vibrato_unit.sv @@
// Stereo vibrato on a modulated delay line. One stereo frame is taken per clock
// when the result side keeps up; each frame returns the pair stored
// 1 + ceil(mod_depth * lfo) entries behind the write index (modulo delay_length),
// read before the incoming pair is written. Between request and result, the
// phase, sine index, lfo value and offset registers form the lfo value and
// offset, a chain of remainder registers reduces the offset modulo the length
// one quotient bit per register, the read address register forms the read
// address and the delay memory is read; its write port and read port are each
// used once per frame. After reset the delay memory is zeroed one entry per
// cycle, during which req_tready stays low; configuration writes are taken at
// any time but must only be issued while no frame is in flight.
module lfo_modulated_delay_vibrato_unit #(
   parameter int DELAY_DEPTH  = 4096,
   parameter int SAMPLE_BITS  = 24,
   parameter int SINE_ENTRIES = 256
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_tvalid,
   output logic                                    req_tready,
   // left_in, right_in
   input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]      req_tdata,
   output logic                                    rsp_tvalid,
   input  logic                                    rsp_tready,
   // left_out, right_out
   output logic [((2*SAMPLE_BITS+7)/8)*8-1:0]      rsp_tdata,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [lmdv_pkg::CSR_ADDR_W-1:0]         csr_index,
   input  logic [lmdv_pkg::CSR_DATA_W-1:0]         csr_data
);

   localparam int TDATA_W = ((2*SAMPLE_BITS+7)/8)*8;
   localparam int PAIR_W  = 2*SAMPLE_BITS;
   localparam int IDX_W   = $clog2(DELAY_DEPTH);
   localparam int LEN_W   = $clog2(DELAY_DEPTH+1);
   localparam int RD_W    = LEN_W + 1;
   localparam int KW      = $clog2(SINE_ENTRIES+1);
   localparam int BACK_W  = lmdv_pkg::BACK_W;
   localparam int LFO_W   = lmdv_pkg::LFO_W;
   localparam int CW      = BACK_W + LEN_W;
   localparam int ST_REM0 = 3;
   localparam int NS      = ST_REM0 + BACK_W + 2;

   typedef logic [LFO_W-1:0] sine_rom_type [SINE_ENTRIES+1];

   function automatic sine_rom_type build_sine_rom();
      sine_rom_type rom;
      logic [63:0]  x;
      logic [63:0]  y;
      logic [63:0]  t;
      logic [63:0]  s;
      for (int i = 0; i < SINE_ENTRIES; i++) begin
         x = (64'(i) << 30) / 64'(SINE_ENTRIES);
         y = (x * x) >> 30;
         t = 64'd5026995 - ((y * 64'd172272) >> 30);
         t = 64'd85569306 - ((y * t) >> 30);
         t = 64'd693598668 - ((y * t) >> 30);
         t = 64'd1686629713 - ((y * t) >> 30);
         s = (x * t) >> 30;
         rom[i] = LFO_W'((s + 64'd8192) >> 14);
      end
      rom[SINE_ENTRIES] = LFO_W'(65536);
      return rom;
   endfunction

   localparam sine_rom_type SINE_ROM = build_sine_rom();

   // configuration
   logic [lmdv_pkg::DEPTH_W-1:0]  depth_ff;
   logic [lmdv_pkg::STEP_W-1:0]   step_ff;
   lmdv_pkg::lfo_shape_type       shape_ff;
   logic [lmdv_pkg::LENGTH_W-1:0] length_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff  <= lmdv_pkg::RST_MOD_DEPTH;
         step_ff   <= lmdv_pkg::RST_PHASE_STEP;
         shape_ff  <= lmdv_pkg::SHAPE_SINE;
         length_ff <= lmdv_pkg::RST_DELAY_LENGTH;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            lmdv_pkg::CSR_MOD_DEPTH:    depth_ff  <= csr_data[lmdv_pkg::DEPTH_W-1:0];
            lmdv_pkg::CSR_PHASE_STEP:   step_ff   <= csr_data[lmdv_pkg::STEP_W-1:0];
            lmdv_pkg::CSR_LFO_SHAPE:
               shape_ff <= lmdv_pkg::lfo_shape_type'(csr_data[lmdv_pkg::SHAPE_W-1:0]);
            lmdv_pkg::CSR_DELAY_LENGTH: length_ff <= csr_data[lmdv_pkg::LENGTH_W-1:0];
            default: ;
         endcase
      end
   end

   logic [LEN_W-1:0] len_eff;

   always_comb begin
      if (length_ff == '0) begin
         len_eff = LEN_W'(1);
      end else if (32'(length_ff) > 32'(DELAY_DEPTH)) begin
         len_eff = LEN_W'(DELAY_DEPTH);
      end else begin
         len_eff = LEN_W'(length_ff);
      end
   end

   // clearing pass
   logic             clear_ff;
   logic [IDX_W-1:0] clr_idx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff   <= 1'b1;
         clr_idx_ff <= '0;
      end else if (clear_ff) begin
         clr_idx_ff <= clr_idx_ff + 1'b1;
         if (32'(clr_idx_ff) == DELAY_DEPTH - 1) begin
            clear_ff <= 1'b0;
         end
      end
   end

   // pipeline flow control
   logic              v_ff [NS];
   logic              rdy  [NS+1];
   logic [IDX_W-1:0]  w_pipe_ff   [NS];
   logic [PAIR_W-1:0] smp_pipe_ff [NS];
   logic              req_acc;
   logic              issue;
   logic              out_valid_ff;

   always_comb begin
      rdy[NS] = !out_valid_ff || rsp_tready;
      for (int s = NS-1; s >= 0; s--) begin
         rdy[s] = !v_ff[s] || rdy[s+1];
      end
   end

   assign req_tready = rdy[0] && !clear_ff;
   assign req_acc    = req_tvalid && req_tready;
   assign issue      = v_ff[NS-1] && rdy[NS];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < NS; s++) begin
            v_ff[s] <= 1'b0;
         end
      end else begin
         for (int s = 0; s < NS; s++) begin
            if (rdy[s]) begin
               v_ff[s] <= (s == 0) ? req_acc : v_ff[(s == 0) ? 0 : s-1];
            end
         end
      end
   end

   // write index and phase
   logic [IDX_W-1:0]             wi_ff;
   logic [lmdv_pkg::PHASE_W-1:0] phase_ff;
   logic [IDX_W-1:0]             w_cur;
   logic [RD_W-1:0]              w_inc;

   assign w_cur = (RD_W'(wi_ff) < RD_W'(len_eff)) ? wi_ff : '0;
   assign w_inc = RD_W'(w_cur) + RD_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         wi_ff    <= '0;
         phase_ff <= '0;
      end else if (req_acc) begin
         wi_ff    <= (w_inc >= RD_W'(len_eff)) ? '0 : IDX_W'(w_inc);
         phase_ff <= phase_ff + lmdv_pkg::PHASE_W'(step_ff);
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < NS; s++) begin
         if (rdy[s]) begin
            if (s == 0) begin
               w_pipe_ff[s]   <= w_cur;
               smp_pipe_ff[s] <= req_tdata[PAIR_W-1:0];
            end else begin
               w_pipe_ff[s]   <= w_pipe_ff[(s == 0) ? 0 : s-1];
               smp_pipe_ff[s] <= smp_pipe_ff[(s == 0) ? 0 : s-1];
            end
         end
      end
   end

   // stage 0: phase
   logic [lmdv_pkg::PHASE_W-1:0] ph_ff;

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         ph_ff <= phase_ff;
      end
   end

   // stage 1: sine index, linear shapes
   logic [15:0]       p16;
   logic [LFO_W-1:0]  p2;
   logic [30+KW-1:0]  k_prod;
   logic [KW-1:0]     k_in;
   logic [LFO_W-1:0]  alt_in;
   logic [KW-1:0]     k_ff;
   logic [1:0]        q_ff;
   logic [LFO_W-1:0]  alt_ff;

   assign p16    = ph_ff[31:16];
   assign p2     = {p16, 1'b0};
   assign k_prod = (30+KW)'(ph_ff[29:0]) * (30+KW)'(SINE_ENTRIES);
   assign k_in   = k_prod[30 +: KW];

   always_comb begin
      unique case (shape_ff)
         lmdv_pkg::SHAPE_TRI: begin
            if (p16 < 16'd16384) begin
               alt_in = LFO_W'(32768) + p2;
            end else if (p16 < 16'd49152) begin
               alt_in = LFO_W'(98304) - p2;
            end else begin
               alt_in = p2 - LFO_W'(98304);
            end
         end
         lmdv_pkg::SHAPE_RISE: begin
            alt_in = p16[15] ? LFO_W'(p16) - LFO_W'(32768) : LFO_W'(p16) + LFO_W'(32768);
         end
         lmdv_pkg::SHAPE_FALL: begin
            alt_in = p16[15] ? LFO_W'(98304) - LFO_W'(p16) : LFO_W'(32768) - LFO_W'(p16);
         end
         default: alt_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (rdy[1]) begin
         k_ff   <= k_in;
         q_ff   <= ph_ff[31:30];
         alt_ff <= alt_in;
      end
   end

   // stage 2: lfo value
   logic [KW-1:0]    sine_idx;
   logic [LFO_W-1:0] sine_mag;
   logic [LFO_W:0]   sine_sum;
   logic [LFO_W-1:0] lfo_ff;

   assign sine_idx = q_ff[0] ? KW'(SINE_ENTRIES) - k_ff : k_ff;
   assign sine_mag = SINE_ROM[sine_idx];
   assign sine_sum = q_ff[1] ? (LFO_W+1)'(65536) - (LFO_W+1)'(sine_mag)
                             : (LFO_W+1)'(65536) + (LFO_W+1)'(sine_mag);

   always_ff @(posedge clock) begin
      if (rdy[2]) begin
         lfo_ff <= (shape_ff == lmdv_pkg::SHAPE_SINE) ? sine_sum[LFO_W:1] : alt_ff;
      end
   end

   // stage 3: offset, then remainder by length one bit per stage
   logic [29:0]       off_sum;
   logic [BACK_W-1:0] rem_ff [BACK_W+1];

   assign off_sum = 30'(depth_ff) * 30'(lfo_ff) + 30'd65535;

   always_ff @(posedge clock) begin
      if (rdy[ST_REM0]) begin
         rem_ff[0] <= BACK_W'(off_sum[29:16]) + BACK_W'(1);
      end
   end

   for (genvar t = 0; t < BACK_W; t++) begin : g_rem
      localparam int SH = BACK_W - 1 - t;
      logic [CW-1:0] div_sh;
      logic [CW-1:0] num;
      assign div_sh = CW'(len_eff) << SH;
      assign num    = CW'(rem_ff[t]);
      always_ff @(posedge clock) begin
         if (rdy[ST_REM0+1+t]) begin
            rem_ff[t+1] <= (num >= div_sh) ? BACK_W'(num - div_sh) : rem_ff[t];
         end
      end
   end

   // read address
   logic [RD_W-1:0]  rd_sum;
   logic [IDX_W-1:0] rd_ff;

   assign rd_sum = RD_W'(w_pipe_ff[NS-2]) + RD_W'(len_eff) - RD_W'(rem_ff[BACK_W]);

   always_ff @(posedge clock) begin
      if (rdy[NS-1]) begin
         rd_ff <= (rd_sum >= RD_W'(len_eff)) ? IDX_W'(rd_sum - RD_W'(len_eff))
                                             : IDX_W'(rd_sum);
      end
   end

   // delay memory
   logic [PAIR_W-1:0] store [DELAY_DEPTH];
   logic [PAIR_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (clear_ff) begin
         store[clr_idx_ff] <= '0;
      end else if (issue) begin
         store[w_pipe_ff[NS-1]] <= smp_pipe_ff[NS-1];
      end
      if (issue) begin
         rdata_ff <= store[rd_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (issue) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = TDATA_W'(rdata_ff);

endmodule

@@ rtl/lmdv_checker.sv @@
module lmdv_checker #(
   parameter int SAMPLE_BITS = 24
) (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tready,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [((2*SAMPLE_BITS+7)/8)*8-1:0]  rsp_tdata
);

   // memory clear runs right after reset
   a_no_accept_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !req_tready)
      else $error("request accepted during memory clear");

   a_clear_after_release: assert property (@(posedge clock)
      $fell(reset) |-> !req_tready)
      else $error("ready raised as reset released");

   a_no_result_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result shown without a request transaction");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

endmodule

bind lfo_modulated_delay_vibrato_unit lmdv_checker #(
   .SAMPLE_BITS(SAMPLE_BITS)
) u_lmdv_checker (.*);
